/* design/dq_pkg.sv */
// Shared types and operation codes for the double-ended queue.
package dq_pkg;

	typedef logic [2:0] mode_t;
	typedef logic signed [31:0] word_t;

	localparam mode_t MODE_PUSH_HEAD = 3'd0;
	localparam mode_t MODE_PUSH_TAIL = 3'd1;
	localparam mode_t MODE_POP_HEAD  = 3'd2;
	localparam mode_t MODE_POP_TAIL  = 3'd3;
	localparam mode_t MODE_SEARCH    = 3'd4;

endpackage

/* design/dq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/double_ended_queue.sv */
// Double-ended queue top level: ring buffer in RAM, head/tail words cached in registers.
// Push, unused mode, pop that empties the queue or underflows: done rises in the cycle
//   after the accepting edge, and a new transaction may be accepted in that same cycle.
// Pop leaving entries behind: S_POP waits for one RAM read of the new head or tail word.
// Search: done as for a push if empty, else S_SCAN walks the ring from the head until a hit
//   or until every entry is read; the RAM read port scans one entry a cycle.
// Reset (arst_n low) empties the queue at once; no clearing pass. done cannot be stalled.
module double_ended_queue #(
	parameter int DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dq_pkg::mode_t  mode,
	input  dq_pkg::word_t  value,
	output logic           done,
	output dq_pkg::word_t  popped_value,
	output logic           popped_valid,
	output logic           found,
	output logic           underflow,
	output logic           overflow,
	output logic           empty_res,
	output dq_pkg::word_t  head_value,
	output dq_pkg::word_t  tail_value
);

	import dq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [AW-1:0]  tail_q;     // always head + count - 1 around the ring
	logic [CW-1:0]  count_q;
	word_t          head_val_q; // cached copy of the word at the head
	word_t          tail_val_q; // cached copy of the word at the tail
	word_t          key_q;
	logic [AW-1:0]  scan_ptr_q;
	logic [CW-1:0]  scan_cnt_q; // entries read so far in this search
	logic           pop_tail_q;

	logic           done_q;
	word_t          popped_value_q;
	logic           popped_valid_q;
	logic           found_q;
	logic           underflow_q;
	logic           overflow_q;

	logic           accept;
	logic           is_empty;
	logic           is_full;
	logic           multi;
	logic           hit;
	logic           last;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [31:0]    ram_rdata;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));
	assign multi    = (count_q > CW'(1));
	assign hit      = (word_t'(ram_rdata) == key_q);
	assign last     = (scan_cnt_q == count_q);

	// Status fields come straight from registers: they already reflect the
	// transaction whose strobe is up, and change only at the edge that ends it.
	assign done         = done_q;
	assign popped_value = popped_value_q;
	assign popped_valid = popped_valid_q;
	assign found        = found_q;
	assign underflow    = underflow_q;
	assign overflow     = overflow_q;
	assign empty_res    = is_empty;
	assign head_value   = is_empty ? '0 : head_val_q;
	assign tail_value   = is_empty ? '0 : tail_val_q;

	// RAM port steering: writes only on accepted pushes; reads fetch the new end
	// word after a pop, or walk the ring during a search.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		if (accept) begin
			case (mode)
				MODE_PUSH_HEAD: begin
					ram_we    = !is_full;
					ram_waddr = ptr_dec(head_q);
				end
				MODE_PUSH_TAIL: begin
					ram_we    = !is_full;
					ram_waddr = ptr_inc(tail_q);
				end
				MODE_POP_HEAD: begin
					ram_re    = multi;
					ram_raddr = ptr_inc(head_q);
				end
				MODE_POP_TAIL: begin
					ram_re    = multi;
					ram_raddr = ptr_dec(tail_q);
				end
				MODE_SEARCH: begin
					ram_re    = !is_empty;
					ram_raddr = head_q;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_SCAN && !hit && !last) begin
			ram_re    = 1'b1;
			ram_raddr = ptr_inc(scan_ptr_q);
		end
	end

	dq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= AW'(DEPTH - 1);
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						popped_value_q <= '0;
						popped_valid_q <= 1'b0;
						found_q        <= 1'b0;
						underflow_q    <= 1'b0;
						overflow_q     <= 1'b0;
						case (mode)
							MODE_PUSH_HEAD: begin
								done_q <= 1'b1;
								if (is_full) begin
									overflow_q <= 1'b1;
								end else begin
									head_q     <= ptr_dec(head_q);
									count_q    <= count_q + CW'(1);
									head_val_q <= value;
									if (is_empty) begin
										tail_val_q <= value;
									end
								end
							end
							MODE_PUSH_TAIL: begin
								done_q <= 1'b1;
								if (is_full) begin
									overflow_q <= 1'b1;
								end else begin
									tail_q     <= ptr_inc(tail_q);
									count_q    <= count_q + CW'(1);
									tail_val_q <= value;
									if (is_empty) begin
										head_val_q <= value;
									end
								end
							end
							MODE_POP_HEAD: begin
								if (is_empty) begin
									underflow_q <= 1'b1;
									done_q      <= 1'b1;
								end else begin
									popped_value_q <= head_val_q;
									popped_valid_q <= 1'b1;
									head_q         <= ptr_inc(head_q);
									count_q        <= count_q - CW'(1);
									pop_tail_q     <= 1'b0;
									if (multi) begin
										state_q <= S_POP;
									end else begin
										done_q <= 1'b1;
									end
								end
							end
							MODE_POP_TAIL: begin
								if (is_empty) begin
									underflow_q <= 1'b1;
									done_q      <= 1'b1;
								end else begin
									popped_value_q <= tail_val_q;
									popped_valid_q <= 1'b1;
									tail_q         <= ptr_dec(tail_q);
									count_q        <= count_q - CW'(1);
									pop_tail_q     <= 1'b1;
									if (multi) begin
										state_q <= S_POP;
									end else begin
										done_q <= 1'b1;
									end
								end
							end
							MODE_SEARCH: begin
								key_q <= value;
								if (is_empty) begin
									done_q <= 1'b1;
								end else begin
									scan_ptr_q <= head_q;
									scan_cnt_q <= CW'(1);
									state_q    <= S_SCAN;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_POP: begin
					// RAM has returned the word now at the popped end
					if (pop_tail_q) begin
						tail_val_q <= word_t'(ram_rdata);
					end else begin
						head_val_q <= word_t'(ram_rdata);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (hit || last) begin
						found_q <= hit;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						scan_ptr_q <= ptr_inc(scan_ptr_q);
						scan_cnt_q <= scan_cnt_q + CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result strobe always coincides with the controller being free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
	else $error("result strobe while controller busy");

	// The entry count never exceeds the ring size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
	else $error("entry count beyond depth");

	// A push into a full queue reports overflow in the next cycle.
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_full && (mode == MODE_PUSH_HEAD || mode == MODE_PUSH_TAIL))
		|=> (done_q && overflow_q))
	else $error("full push did not report overflow");

	// A transaction cannot both return a word and underflow.
	a_pop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(popped_valid_q && underflow_q))
	else $error("popped_valid together with underflow");

endmodule
